// File: rtl/core/itp_pkg.sv
// Shared types, constants and the precedence function of the infix-to-postfix converter.
package itp_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int NW              = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_MUL   = 8'h2A;
	localparam logic [7:0] SYM_DIV   = 8'h2F;

	localparam logic OP_SYMBOL = 1'b0;
	localparam logic OP_END    = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic pop;
		logic push;
		logic ovf;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic cnt_zero;
		logic cnt_full;
		logic n_max;
		logic pop_ok;
		logic pend_v;
		logic out_free;
	} sts_t;

	function automatic logic [1:0] rank_of(input logic [7:0] b);
		logic [1:0] r;
		if (b == SYM_PLUS || b == SYM_MINUS) begin
			r = 2'd1;
		end else if (b == SYM_MUL || b == SYM_DIV) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/itp_ctrl.sv
// Controller state machine sequencing reads, pops, pushes and output of each transaction.
module itp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  itp_pkg::sts_t sts,
	output itp_pkg::cmd_t cmd
);

	itp_pkg::state_t state_q;
	itp_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = itp_pkg::ST_READ;
				end
			end
			itp_pkg::ST_READ: begin
				if (sts.cnt_zero || sts.n_max) begin
					state_nxt = sts.is_end ? itp_pkg::ST_FLUSH : itp_pkg::ST_PUSH;
				end else begin
					state_nxt = itp_pkg::ST_EVAL;
				end
			end
			itp_pkg::ST_EVAL: begin
				if (!sts.pop_ok) begin
					state_nxt = itp_pkg::ST_PUSH;
				end else if (!sts.pend_v || sts.out_free) begin
					state_nxt = itp_pkg::ST_READ;
				end
			end
			itp_pkg::ST_PUSH: begin
				if (!sts.cnt_full || sts.n_max || !sts.pend_v || sts.out_free) begin
					state_nxt = itp_pkg::ST_FLUSH;
				end
			end
			itp_pkg::ST_FLUSH: begin
				if (!sts.pend_v || sts.out_free) begin
					state_nxt = itp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = itp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			itp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			itp_pkg::ST_READ: begin
				cmd.rd = !(sts.cnt_zero || sts.n_max);
			end
			itp_pkg::ST_EVAL: begin
				cmd.pop = sts.pop_ok && (!sts.pend_v || sts.out_free);
			end
			itp_pkg::ST_PUSH: begin
				cmd.push = !sts.cnt_full;
				cmd.ovf  = sts.cnt_full && !sts.n_max && (!sts.pend_v || sts.out_free);
			end
			itp_pkg::ST_FLUSH: begin
				cmd.flush = sts.pend_v && sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/core/itp_dp.sv
// Datapath: operator stack memory, counters, pending result and output register.
module itp_dp #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          opcode,
	input  logic [7:0]    symbol,
	input  itp_pkg::cmd_t cmd,
	output itp_pkg::sts_t sts,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_symbol,
	output logic          last,
	output logic          overflow
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [7:0]           mem [STACK_DEPTH];
	logic [7:0]           rd_q;
	logic [CW-1:0]        cnt_q;
	logic [itp_pkg::NW-1:0] n_q;
	logic                 op_q;
	logic [7:0]           sym_q;
	logic                 pend_v_q;
	logic [7:0]           pend_sym_q;
	logic                 pend_ovf_q;
	logic                 out_valid_q;
	logic [7:0]           out_sym_q;
	logic                 out_last_q;
	logic                 out_ovf_q;
	logic                 out_load;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[AW'(cnt_q)] <= sym_q;
		end
		if (cmd.rd) begin
			rd_q <= mem[AW'(cnt_q - CW'(1))];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			sym_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
		end else begin
			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.pop || cmd.ovf) begin
				n_q <= n_q + itp_pkg::NW'(1);
			end
			if (cmd.pop) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (cmd.push) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.pop || cmd.ovf) begin
			pend_v_q <= 1'b1;
		end else if (cmd.flush) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop || cmd.ovf) begin
			pend_sym_q <= cmd.pop ? rd_q : 8'h00;
			pend_ovf_q <= cmd.ovf;
		end
	end

	assign out_load = cmd.flush || ((cmd.pop || cmd.ovf) && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sym_q  <= pend_sym_q;
			out_ovf_q  <= pend_ovf_q;
			out_last_q <= cmd.flush;
		end
	end

	always_comb begin
		sts.is_end   = (op_q == itp_pkg::OP_END);
		sts.cnt_zero = (cnt_q == '0);
		sts.cnt_full = (cnt_q == CW'(STACK_DEPTH));
		sts.n_max    = (n_q == itp_pkg::NW'(itp_pkg::MAX_RESULTS));
		sts.pop_ok   = (op_q == itp_pkg::OP_END) ||
			(itp_pkg::rank_of(sym_q) <= itp_pkg::rank_of(rd_q));
		sts.pend_v   = pend_v_q;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign out_symbol = out_sym_q;
	assign last       = out_last_q;
	assign overflow   = out_ovf_q;

endmodule

// File: rtl/core/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: controller plus datapath.
// Steps: a symbol is loaded in ST_IDLE and passes ST_READ, ST_PUSH and ST_FLUSH (an end skips
// ST_PUSH). On a non-empty stack each top entry first takes a registered read in ST_READ, then
// a compare in ST_EVAL. The final result shows on the output in the cycle after the flush.
// Throughput: one transaction at a time; in_stall stays high until the controller is idle.
// A result waiting on a stalled output holds the controller once a newer one or flush is due.
// Reset (arst_n low, asynchronous) empties the stack and clears all valid flags; no clearing pass.
module infix_to_postfix_converter_top #(
	parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       opcode,
	input  logic [7:0] symbol,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_symbol,
	output logic       last,
	output logic       overflow
);

	itp_pkg::cmd_t cmd;
	itp_pkg::sts_t sts;

	itp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	itp_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.symbol     (symbol),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_symbol (out_symbol),
		.last       (last),
		.overflow   (overflow)
	);

endmodule

// File: rtl/core/itp_chk.sv
// Port-level checker for the infix-to-postfix converter and its bind to the top level.
module itp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_symbol,
	input logic       last,
	input logic       overflow
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(last) &&
			$stable(overflow))
		else $error("stalled result transaction changed");

	a_ovf_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> last && (out_symbol == 8'h00))
		else $error("overflow result not final or carries a symbol");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while previous transaction still in work");

	a_busy_two: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> ##1 in_stall)
		else $error("transaction finished too early");

endmodule

bind infix_to_postfix_converter_top itp_chk u_itp_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.out_symbol (out_symbol),
	.last       (last),
	.overflow   (overflow)
);
